// File: rtl/core/sstf_pkg.sv
// Package with the codes, word types and status transition functions of the severity sensor transition FSM.
`timescale 1ns / 1ps

package sstf_pkg;

   localparam int unsigned StatusWidth = 4;
   localparam int unsigned LevelWidth = 3;
   localparam int unsigned OpWidth = 2;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth = 1;

   localparam logic [OpWidth-1:0] OpSet = 2'd0;
   localparam logic [OpWidth-1:0] OpRead = 2'd1;
   localparam logic [OpWidth-1:0] OpRearm = 2'd2;

   localparam logic [LevelWidth-1:0] LvlOk = 3'd0;
   localparam logic [LevelWidth-1:0] LvlNonCritical = 3'd1;
   localparam logic [LevelWidth-1:0] LvlCritical = 3'd2;
   localparam logic [LevelWidth-1:0] LvlNonRecoverable = 3'd3;
   localparam logic [LevelWidth-1:0] LvlMonitor = 3'd4;
   localparam logic [LevelWidth-1:0] LvlInfo = 3'd5;

   localparam logic [StatusWidth-1:0] StToOk = 4'd0;
   localparam logic [StatusWidth-1:0] StNcFromOk = 4'd1;
   localparam logic [StatusWidth-1:0] StCrFromLess = 4'd2;
   localparam logic [StatusWidth-1:0] StNrFromLess = 4'd3;
   localparam logic [StatusWidth-1:0] StNcFromMore = 4'd4;
   localparam logic [StatusWidth-1:0] StCrFromNr = 4'd5;
   localparam logic [StatusWidth-1:0] StNr = 4'd6;
   localparam logic [StatusWidth-1:0] StMonitor = 4'd7;
   localparam logic [StatusWidth-1:0] StInfo = 4'd8;

   localparam logic [CsrIndexWidth-1:0] CsrEventsEnabled = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrScanningEnabled = 1'd1;

   localparam logic [7:0] EventAssertMark = 8'h40;
   localparam logic [7:0] FlagEventsEnabled = 8'h80;
   localparam logic [7:0] FlagScanningEnabled = 8'h40;

   localparam logic [1:0] LenNone = 2'd0;
   localparam logic [1:0] LenRearm = 2'd1;
   localparam logic [1:0] LenTransition = 2'd2;

   typedef struct packed {
      logic [OpWidth-1:0] operation;
      logic [LevelWidth-1:0] level;
      logic event_request;
   } request_type;

   typedef struct packed {
      logic event_valid;
      logic [7:0] event_first_byte;
      logic [7:0] event_second_byte;
      logic [1:0] event_length;
      logic level_error;
      logic [7:0] reading_flags;
      logic [15:0] state_mask;
      logic [LevelWidth-1:0] raw_level;
      logic [StatusWidth-1:0] current_status;
      logic reading_valid;
   } result_type;

   function automatic logic [StatusWidth-1:0] next_noncritical(
      input logic [StatusWidth-1:0] prior_status);
      logic [StatusWidth-1:0] nxt;
      nxt = (prior_status inside {[StCrFromLess:StNr]}) ? StNcFromMore : StNcFromOk;
      return nxt;
   endfunction

   function automatic logic [StatusWidth-1:0] next_critical(
      input logic [StatusWidth-1:0] prior_status);
      logic [StatusWidth-1:0] nxt;
      nxt = (prior_status inside {StNrFromLess, StCrFromNr, StNr}) ?
            StCrFromNr : StCrFromLess;
      return nxt;
   endfunction

   function automatic logic [StatusWidth-1:0] next_nonrecoverable(
      input logic [StatusWidth-1:0] prior_status);
      logic [StatusWidth-1:0] nxt;
      nxt = (prior_status inside {[StNr:4'd15]}) ? StNr : StNrFromLess;
      return nxt;
   endfunction

   function automatic logic [LevelWidth-1:0] raw_of_status(
      input logic [StatusWidth-1:0] status);
      logic [LevelWidth-1:0] raw;
      case (status)
         StToOk: raw = LvlOk;
         StNcFromOk, StNcFromMore: raw = LvlNonCritical;
         StCrFromLess, StCrFromNr: raw = LvlCritical;
         StMonitor: raw = LvlMonitor;
         StInfo: raw = LvlInfo;
         default: raw = LvlNonRecoverable;
      endcase
      return raw;
   endfunction

endpackage

// File: rtl/core/sstf_channels.sv
// Channel interfaces for the request and response words of the severity sensor FSM.
`timescale 1ns / 1ps

interface sstf_req_if;
   logic valid;
   logic ready;
   logic [sstf_pkg::OpWidth-1:0] operation;
   logic [sstf_pkg::LevelWidth-1:0] level;
   logic event_request;

   modport source(output valid, output operation, output level, output event_request,
                  input ready);
   modport sink(input valid, input operation, input level, input event_request,
                output ready);
endinterface

interface sstf_rsp_if;
   logic valid;
   logic ready;
   logic event_valid;
   logic [7:0] event_first_byte;
   logic [7:0] event_second_byte;
   logic [1:0] event_length;
   logic level_error;
   logic [7:0] reading_flags;
   logic [15:0] state_mask;
   logic [sstf_pkg::LevelWidth-1:0] raw_level;
   logic [sstf_pkg::StatusWidth-1:0] current_status;
   logic reading_valid;

   modport source(output valid, output event_valid, output event_first_byte,
                  output event_second_byte, output event_length, output level_error,
                  output reading_flags, output state_mask, output raw_level,
                  output current_status, output reading_valid, input ready);
   modport sink(input valid, input event_valid, input event_first_byte,
                input event_second_byte, input event_length, input level_error,
                input reading_flags, input state_mask, input raw_level,
                input current_status, input reading_valid, output ready);
endinterface

// File: rtl/core/sstf_step.sv
// Next-status and response word logic for one request word.
`timescale 1ns / 1ps

module sstf_step (
   input  logic [sstf_pkg::StatusWidth-1:0] prior_status,
   input  sstf_pkg::request_type            request,
   input  logic                             events_enabled,
   input  logic                             scanning_enabled,
   output logic [sstf_pkg::StatusWidth-1:0] next_status,
   output sstf_pkg::result_type             result
);

   logic [sstf_pkg::StatusWidth-1:0] candidate;
   logic level_ok;
   logic [sstf_pkg::StatusWidth-1:0] status_after;

   always_comb begin
      level_ok = 1'b1;
      case (request.level)
         sstf_pkg::LvlOk: candidate = sstf_pkg::StToOk;
         sstf_pkg::LvlNonCritical: candidate = sstf_pkg::next_noncritical(prior_status);
         sstf_pkg::LvlCritical: candidate = sstf_pkg::next_critical(prior_status);
         sstf_pkg::LvlNonRecoverable: candidate = sstf_pkg::next_nonrecoverable(prior_status);
         sstf_pkg::LvlMonitor: candidate = sstf_pkg::StMonitor;
         sstf_pkg::LvlInfo: candidate = sstf_pkg::StInfo;
         default: begin
            candidate = prior_status;
            level_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      status_after = prior_status;
      result.event_valid = 1'b0;
      result.event_first_byte = 8'h00;
      result.event_second_byte = 8'h00;
      result.event_length = sstf_pkg::LenNone;
      result.level_error = 1'b0;
      case (request.operation)
         sstf_pkg::OpSet: begin
            if (!level_ok) begin
               result.level_error = 1'b1;
            end else begin
               status_after = candidate;
               if (request.event_request && (candidate != prior_status)) begin
                  result.event_valid = 1'b1;
                  result.event_first_byte = sstf_pkg::EventAssertMark | {4'h0, candidate};
                  result.event_second_byte = {4'h0, prior_status};
                  result.event_length = sstf_pkg::LenTransition;
               end
            end
         end
         sstf_pkg::OpRearm: begin
            result.event_valid = 1'b1;
            result.event_first_byte = {4'h0, prior_status};
            result.event_length = sstf_pkg::LenRearm;
         end
         default: begin
         end
      endcase
      result.reading_flags = (events_enabled ? sstf_pkg::FlagEventsEnabled : 8'h00)
                           | (scanning_enabled ? sstf_pkg::FlagScanningEnabled : 8'h00);
      result.state_mask = 16'h0001 << status_after;
      result.raw_level = sstf_pkg::raw_of_status(status_after);
      result.current_status = status_after;
      result.reading_valid = 1'b1;
   end

   assign next_status = status_after;

endmodule

// File: rtl/core/severity_sensor_transition_fsm.sv
// Top level of the severity sensor transition FSM with request and response registers.
//
//   Channel   Dir   Content
//   req_port  in    operation, level, event_request
//   rsp_port  out   event bytes, level error and status view, one word per request
//   csr_*     in    write of events_enabled (index 0) or scanning_enabled (index 1)
//
// A request word passes through the input register and then the response register.
// A new word is taken every cycle while the response side keeps taking words.
// Reset clears the status to transition to OK and sets both enables.
// While the response word is stalled, one more word is taken into the input register.
`timescale 1ns / 1ps

module severity_sensor_transition_fsm (
   input  logic                                 clock,
   input  logic                                 reset,
   sstf_req_if.sink                             req_port,
   sstf_rsp_if.source                           rsp_port,
   input  logic                                 csr_write_enable,
   input  logic [sstf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [sstf_pkg::CsrDataWidth-1:0]    csr_write_data
);

   logic events_enabled_ff;
   logic scanning_enabled_ff;
   logic [sstf_pkg::StatusWidth-1:0] status_ff;
   logic [sstf_pkg::StatusWidth-1:0] status_in;
   logic req_valid_ff;
   sstf_pkg::request_type req_ff;
   logic rsp_valid_ff;
   sstf_pkg::result_type rsp_ff;
   sstf_pkg::result_type rsp_in;
   logic advance;

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !req_valid_ff || advance;

   sstf_step u_step (
      .prior_status     (status_ff),
      .request          (req_ff),
      .events_enabled   (events_enabled_ff),
      .scanning_enabled (scanning_enabled_ff),
      .next_status      (status_in),
      .result           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         events_enabled_ff <= 1'b1;
         scanning_enabled_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            sstf_pkg::CsrEventsEnabled: events_enabled_ff <= csr_write_data[0];
            sstf_pkg::CsrScanningEnabled: scanning_enabled_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         req_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         req_ff.operation <= req_port.operation;
         req_ff.level <= req_port.level;
         req_ff.event_request <= req_port.event_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= sstf_pkg::StToOk;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         status_ff <= status_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.event_valid = rsp_ff.event_valid;
   assign rsp_port.event_first_byte = rsp_ff.event_first_byte;
   assign rsp_port.event_second_byte = rsp_ff.event_second_byte;
   assign rsp_port.event_length = rsp_ff.event_length;
   assign rsp_port.level_error = rsp_ff.level_error;
   assign rsp_port.reading_flags = rsp_ff.reading_flags;
   assign rsp_port.state_mask = rsp_ff.state_mask;
   assign rsp_port.raw_level = rsp_ff.raw_level;
   assign rsp_port.current_status = rsp_ff.current_status;
   assign rsp_port.reading_valid = rsp_ff.reading_valid;

   a_status_in_range: assert property (@(posedge clock) disable iff (reset)
      status_ff <= sstf_pkg::StInfo)
      else $error("Transition status left the defined codes.");

   a_rsp_tracks_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.current_status == status_ff))
      else $error("Response word status differs from the status register.");

   a_event_state_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_ff.state_mask))
      else $error("Event state is not one-hot.");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_ff)))
      else $error("A waiting request word was lost or changed.");

   a_status_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(status_ff))
      else $error("Status changed without a request word moving on.");

endmodule
